### design/awu_pkg.sv
`timescale 1ns / 1ps

package awu_pkg;

    // Sizes
    localparam int NUM_WEIGHTS = 1024;
    localparam int SLOT_W      = $clog2(NUM_WEIGHTS);
    localparam int IDX_W       = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Queue between update front and step back
    localparam int Q_DEPTH   = 8;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = Q_PTR_W + 1;
    localparam int FRONT_LAT = 3;

    // Root and divide pipelines: 32 result bits each
    localparam int RES_BITS    = 32;
    localparam int ROOT_STAGES = 16;
    localparam int ROOT_ITERS  = RES_BITS / ROOT_STAGES;
    localparam int DIV_STAGES  = 16;
    localparam int DIV_ITERS   = RES_BITS / DIV_STAGES;

    localparam logic [24:0] ONE_Q24 = 25'h100_0000;
    localparam logic [47:0] MAX_V   = 48'hFFFF_FFFF_FFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_ONE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_TWO       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON_TERM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_SCALE_ONE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_SCALE_TWO = 3'd5;

    typedef struct packed {
        logic [23:0] beta_one;
        logic [23:0] beta_two;
        logic [23:0] learning_rate;
        logic [15:0] epsilon_term;
        logic [31:0] bias_scale_one;
        logic [31:0] bias_scale_two;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        beta_one:       24'd15099494,
        beta_two:       24'd16760439,
        learning_rate:  24'd16777,
        epsilon_term:   16'd429,
        bias_scale_one: 32'd655360,
        bias_scale_two: 32'd65536000
    };

    typedef struct packed {
        logic [IDX_W-1:0]  weight_index;
        logic signed [31:0] grad_value;
        logic              fresh;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  out_index;
        logic signed [31:0] weight_step;
        logic              clipped;
    } out_item_t;

    // Updated moments handed from front to back
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             m_pos;
        logic [31:0]      mmag;
        logic [47:0]      v_new;
    } moment_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             m_pos;
        logic [46:0]      mc;
    } root_side_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             m_pos;
        logic             nz;
        logic             sat;
    } div_side_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
    } root_step_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
    } div_step_t;

    // One digit of the restoring square root
    function automatic root_step_t sqrt_step(input root_step_t st, input logic [1:0] pair);
        root_step_t  res;
        logic [35:0] acc;
        logic [35:0] trial;
        acc   = {st.rem, pair};
        trial = {2'b00, st.root, 2'b01};
        if (acc >= trial)
        begin
            res.rem  = 34'(acc - trial);
            res.root = {st.root[30:0], 1'b1};
        end
        else
        begin
            res.rem  = acc[33:0];
            res.root = {st.root[30:0], 1'b0};
        end
        return res;
    endfunction

    // One bit of the restoring divide
    function automatic div_step_t div_step(input div_step_t st, input logic nbit,
                                           input logic [31:0] dvs);
        div_step_t   res;
        logic [32:0] acc;
        acc = {st.rem, nbit};
        if (acc >= {1'b0, dvs})
        begin
            res.rem = 32'(acc - {1'b0, dvs});
            res.quo = {st.quo[30:0], 1'b1};
        end
        else
        begin
            res.rem = acc[31:0];
            res.quo = {st.quo[30:0], 1'b0};
        end
        return res;
    endfunction

endpackage

### design/awu_front.sv
`timescale 1ns / 1ps

module awu_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  awu_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  awu_pkg::in_item_t             in_data,
    input  logic [awu_pkg::Q_CNT_W-1:0]   q_count,
    output logic                          push,
    output awu_pkg::moment_t              push_data
);

    // Moment memories
    logic [31:0] m_mem [awu_pkg::NUM_WEIGHTS];
    logic [47:0] v_mem [awu_pkg::NUM_WEIGHTS];
    logic [31:0] m_rd_reg;
    logic [47:0] v_rd_reg;

    // Input holding stage
    logic                        s0_valid_reg;
    logic                        s0_valid_next;
    awu_pkg::in_item_t           s0_item_reg;
    logic [awu_pkg::SLOT_W-1:0]  s0_slot;
    logic                        hazard;
    logic [awu_pkg::Q_CNT_W:0]   credit_used;
    logic                        go;
    logic                        accept;

    // Update pipeline
    logic                        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [awu_pkg::SLOT_W-1:0]  s1_slot_reg, s2_slot_reg, s3_slot_reg;
    logic [awu_pkg::IDX_W-1:0]   s1_index_reg, s2_index_reg, s3_index_reg;
    logic signed [31:0]          s1_g_reg;
    logic                        s1_fresh_reg;

    logic signed [31:0]          m_old;
    logic [47:0]                 v_old;
    logic [31:0]                 gmag;
    logic [24:0]                 c1;
    logic signed [56:0]          pm;
    logic signed [57:0]          pg;
    logic [63:0]                 sq;

    logic signed [56:0]          s2_pm_reg;
    logic signed [57:0]          s2_pg_reg;
    logic [63:0]                 s2_sq_reg;
    logic [47:0]                 s2_v_reg;

    logic signed [58:0]          msum;
    logic signed [31:0]          m_new;
    logic [63:0]                 qsum;
    logic [46:0]                 q;
    logic [24:0]                 c2;
    logic [47:0]                 hv, lv, hq;
    logic [48:0]                 lq;

    logic signed [31:0]          s3_m_reg;
    logic [47:0]                 s3_hv_reg, s3_lv_reg, s3_hq_reg;
    logic [48:0]                 s3_lq_reg;

    logic [49:0]                 hsum, lsum, vsum;
    logic [47:0]                 v_new;

    function automatic logic signed [58:0] pm_ext(input logic signed [56:0] a);
        return 59'(a);
    endfunction

    // Classify: a stored-moment read must wait for an in-flight write to its slot
    assign s0_slot = awu_pkg::SLOT_W'(32'(s0_item_reg.weight_index) % awu_pkg::NUM_WEIGHTS);
    assign hazard  = ~s0_item_reg.fresh &
                     ((s1_valid_reg & (s1_slot_reg == s0_slot)) |
                      (s2_valid_reg & (s2_slot_reg == s0_slot)) |
                      (s3_valid_reg & (s3_slot_reg == s0_slot)));

    // Queue credit covers items still in the update pipeline
    assign credit_used = (awu_pkg::Q_CNT_W + 1)'(q_count) +
                         (awu_pkg::Q_CNT_W + 1)'(s1_valid_reg) +
                         (awu_pkg::Q_CNT_W + 1)'(s2_valid_reg) +
                         (awu_pkg::Q_CNT_W + 1)'(s3_valid_reg);
    assign go       = s0_valid_reg & ~hazard &
                      (credit_used < (awu_pkg::Q_CNT_W + 1)'(awu_pkg::Q_DEPTH));
    assign in_stall = s0_valid_reg & ~go;
    assign accept   = in_valid & ~in_stall;
    assign s0_valid_next = accept | (s0_valid_reg & ~go);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= go;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s0_item_reg <= in_data;
    end

    // Memory ports: write back at S3, read when an item leaves S0
    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
            m_mem[s3_slot_reg] <= s3_m_reg;
        if (go)
            m_rd_reg <= m_mem[s0_slot];
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
            v_mem[s3_slot_reg] <= v_new;
        if (go)
            v_rd_reg <= v_mem[s0_slot];
    end

    // S1: products for the first moment and the squared gradient
    assign m_old = s1_fresh_reg ? 32'sd0 : $signed(m_rd_reg);
    assign v_old = s1_fresh_reg ? 48'd0 : v_rd_reg;
    assign gmag  = s1_g_reg[31] ? 32'(32'd0 - s1_g_reg) : s1_g_reg;
    assign c1    = awu_pkg::ONE_Q24 - {1'b0, cfg.beta_one};
    assign pm    = $signed({1'b0, cfg.beta_one}) * m_old;
    assign pg    = $signed({1'b0, c1}) * s1_g_reg;
    assign sq    = 64'(gmag) * 64'(gmag);

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            s1_slot_reg  <= s0_slot;
            s1_index_reg <= s0_item_reg.weight_index;
            s1_g_reg     <= s0_item_reg.grad_value;
            s1_fresh_reg <= s0_item_reg.fresh;
        end
        s2_pm_reg    <= pm;
        s2_pg_reg    <= pg;
        s2_sq_reg    <= sq;
        s2_v_reg     <= v_old;
        s2_slot_reg  <= s1_slot_reg;
        s2_index_reg <= s1_index_reg;
    end

    // S2: new first moment, g^2 in Q16.32, second-moment partial products
    assign msum  = pm_ext(s2_pm_reg) + s2_pg_reg + 59'sd8388608;
    assign m_new = msum[55:24];
    assign qsum  = s2_sq_reg + 64'd32768;
    assign q     = qsum[62:16];
    assign c2    = awu_pkg::ONE_Q24 - {1'b0, cfg.beta_two};
    assign hv    = 48'(cfg.beta_two) * 48'(s2_v_reg[47:24]);
    assign lv    = 48'(cfg.beta_two) * 48'(s2_v_reg[23:0]);
    assign hq    = 48'(c2) * 48'(q[46:24]);
    assign lq    = 49'(c2) * 49'(q[23:0]);

    always_ff @(posedge clk)
    begin
        s3_m_reg     <= m_new;
        s3_hv_reg    <= hv;
        s3_lv_reg    <= lv;
        s3_hq_reg    <= hq;
        s3_lq_reg    <= lq;
        s3_slot_reg  <= s2_slot_reg;
        s3_index_reg <= s2_index_reg;
    end

    // S3: combine high and low halves, round, saturate to 48 bits
    assign hsum  = 50'(s3_hv_reg) + 50'(s3_hq_reg);
    assign lsum  = 50'(s3_lv_reg) + 50'(s3_lq_reg) + 50'd8388608;
    assign vsum  = hsum + 50'(lsum[49:24]);
    assign v_new = (vsum[49:48] != 2'b00) ? awu_pkg::MAX_V : vsum[47:0];

    assign push            = s3_valid_reg;
    assign push_data.index = s3_index_reg;
    assign push_data.m_pos = ~s3_m_reg[31] & (s3_m_reg != 32'sd0);
    assign push_data.mmag  = s3_m_reg[31] ? 32'(32'd0 - s3_m_reg) : s3_m_reg;
    assign push_data.v_new = v_new;

endmodule

### design/awu_queue.sv
`timescale 1ns / 1ps

module awu_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  awu_pkg::moment_t            push_data,
    input  logic                        pop,
    output logic                        not_empty,
    output awu_pkg::moment_t            head_data,
    output logic [awu_pkg::Q_CNT_W-1:0] count
);

    awu_pkg::moment_t                entry_reg [awu_pkg::Q_DEPTH];
    logic [awu_pkg::Q_PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [awu_pkg::Q_CNT_W-1:0]     count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign head_data = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push & ~pop)
            count_next = count_reg + 1'b1;
        else if (pop & ~push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### design/awu_sqrt.sv
`timescale 1ns / 1ps

module awu_sqrt (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [47:0]          x,
    input  awu_pkg::root_side_t  side_in,
    output logic                 out_valid,
    output logic [31:0]          root,
    output awu_pkg::root_side_t  side_out
);

    localparam int N = awu_pkg::ROOT_STAGES;

    logic                valid_reg [N];
    logic [47:0]         x_reg     [N];
    logic [33:0]         rem_reg   [N];
    logic [31:0]         root_reg  [N];
    awu_pkg::root_side_t side_reg  [N];

    logic                valid_src [N];
    logic [47:0]         x_src     [N];
    logic [33:0]         rem_src   [N];
    logic [31:0]         root_src  [N];
    awu_pkg::root_side_t side_src  [N];
    logic [33:0]         rem_next  [N];
    logic [31:0]         root_next [N];

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        if (s == 0)
        begin : g_first
            assign valid_src[s] = in_valid;
            assign x_src[s]     = x;
            assign rem_src[s]   = '0;
            assign root_src[s]  = '0;
            assign side_src[s]  = side_in;
        end
        else
        begin : g_rest
            assign valid_src[s] = valid_reg[s-1];
            assign x_src[s]     = x_reg[s-1];
            assign rem_src[s]   = rem_reg[s-1];
            assign root_src[s]  = root_reg[s-1];
            assign side_src[s]  = side_reg[s-1];
        end

        // Two root digits per stage; the radicand is X scaled by 2^16
        always_comb
        begin
            logic [63:0]         xin;
            awu_pkg::root_step_t st;
            xin     = {x_src[s], 16'h0000};
            st.rem  = rem_src[s];
            st.root = root_src[s];
            for (int j = 0; j < awu_pkg::ROOT_ITERS; j++)
                st = awu_pkg::sqrt_step(st, xin[63 - 2 * (s * awu_pkg::ROOT_ITERS + j) -: 2]);
            rem_next[s]  = st.rem;
            root_next[s] = st.root;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= valid_src[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s]    <= x_src[s];
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                side_reg[s] <= side_src[s];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign root      = root_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

### design/awu_div.sv
`timescale 1ns / 1ps

module awu_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [31:0]         rem0,
    input  logic [31:0]         nlow,
    input  logic [31:0]         dvs,
    input  awu_pkg::div_side_t  side_in,
    output logic                out_valid,
    output logic [31:0]         quo,
    output awu_pkg::div_side_t  side_out
);

    localparam int N = awu_pkg::DIV_STAGES;

    logic               valid_reg [N];
    logic [31:0]        rem_reg   [N];
    logic [31:0]        quo_reg   [N];
    logic [31:0]        nlow_reg  [N];
    logic [31:0]        dvs_reg   [N];
    awu_pkg::div_side_t side_reg  [N];

    logic               valid_src [N];
    logic [31:0]        rem_src   [N];
    logic [31:0]        quo_src   [N];
    logic [31:0]        nlow_src  [N];
    logic [31:0]        dvs_src   [N];
    awu_pkg::div_side_t side_src  [N];
    logic [31:0]        rem_next  [N];
    logic [31:0]        quo_next  [N];

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        if (s == 0)
        begin : g_first
            assign valid_src[s] = in_valid;
            assign rem_src[s]   = rem0;
            assign quo_src[s]   = '0;
            assign nlow_src[s]  = nlow;
            assign dvs_src[s]   = dvs;
            assign side_src[s]  = side_in;
        end
        else
        begin : g_rest
            assign valid_src[s] = valid_reg[s-1];
            assign rem_src[s]   = rem_reg[s-1];
            assign quo_src[s]   = quo_reg[s-1];
            assign nlow_src[s]  = nlow_reg[s-1];
            assign dvs_src[s]   = dvs_reg[s-1];
            assign side_src[s]  = side_reg[s-1];
        end

        // Two quotient bits per stage
        always_comb
        begin
            awu_pkg::div_step_t st;
            st.rem = rem_src[s];
            st.quo = quo_src[s];
            for (int j = 0; j < awu_pkg::DIV_ITERS; j++)
                st = awu_pkg::div_step(st, nlow_src[s][31 - (s * awu_pkg::DIV_ITERS + j)],
                                       dvs_src[s]);
            rem_next[s] = st.rem;
            quo_next[s] = st.quo;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= valid_src[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next[s];
                quo_reg[s]  <= quo_next[s];
                nlow_reg[s] <= nlow_src[s];
                dvs_reg[s]  <= dvs_src[s];
                side_reg[s] <= side_src[s];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign quo       = quo_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

### design/awu_back.sv
`timescale 1ns / 1ps

module awu_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  awu_pkg::cfg_t        cfg,
    input  logic                 q_valid,
    input  awu_pkg::moment_t     q_data,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output awu_pkg::out_item_t   out_data
);

    logic                en;

    logic                p0_valid_reg;
    awu_pkg::moment_t    p0_reg;

    logic                p1_valid_reg;
    logic [63:0]         p1_mprod_reg, p1_hprod_reg;
    logic [47:0]         p1_lprod_reg;
    logic [awu_pkg::IDX_W-1:0] p1_index_reg;
    logic                p1_mpos_reg;
    logic [63:0]         mprod, hprod;
    logic [47:0]         lprod;

    logic [63:0]         mc_sum;
    logic [48:0]         rl_sum;
    logic [49:0]         x_sum;
    logic [47:0]         x_val;
    logic                p2_valid_reg;
    logic [47:0]         p2_x_reg;
    awu_pkg::root_side_t p2_side_reg;
    awu_pkg::root_side_t p2_side_next;

    logic                rt_valid;
    logic [31:0]         rt_root;
    awu_pkg::root_side_t rt_side;

    logic                p3_valid_reg;
    logic [47:0]         p3_nlo_reg;
    logic [46:0]         p3_nhi_reg;
    logic [31:0]         p3_root_reg;
    awu_pkg::root_side_t p3_side_reg;

    logic [70:0]         num;
    logic                p4_valid_reg;
    logic [31:0]         p4_rem_reg, p4_nlow_reg, p4_dvs_reg;
    awu_pkg::div_side_t  p4_side_reg;
    awu_pkg::div_side_t  p4_side_next;

    logic                dv_valid;
    logic [31:0]         dv_quo;
    awu_pkg::div_side_t  dv_side;

    logic [31:0]         limit;
    logic [31:0]         mag;
    logic                clip;
    logic                out_valid_reg;
    awu_pkg::out_item_t  out_reg, out_next;

    // Whole back pipeline moves unless a finished step is held
    assign en    = ~(out_valid_reg & out_stall);
    assign q_pop = en & q_valid;

    always_ff @(posedge clk)
    begin
        if (q_pop)
            p0_reg <= q_data;
    end

    // P1: bias-scale products
    assign mprod = 64'(p0_reg.mmag) * 64'(cfg.bias_scale_one);
    assign hprod = 64'(p0_reg.v_new[47:16]) * 64'(cfg.bias_scale_two);
    assign lprod = 48'(p0_reg.v_new[15:0]) * 48'(cfg.bias_scale_two);

    // P2: round, add epsilon, saturate the radicand
    assign mc_sum = p1_mprod_reg + 64'd32768;
    assign rl_sum = 49'(p1_lprod_reg) + 49'd32768;
    assign x_sum  = 50'(p1_hprod_reg[47:0]) + 50'(rl_sum[48:16]) + 50'(cfg.epsilon_term);
    always_comb
    begin
        if (p1_hprod_reg[63:48] != 16'h0000 || x_sum[49:48] != 2'b00)
            x_val = awu_pkg::MAX_V;
        else
            x_val = x_sum[47:0];
    end
    assign p2_side_next.index = p1_index_reg;
    assign p2_side_next.m_pos = p1_mpos_reg;
    assign p2_side_next.mc    = mc_sum[62:16];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_mprod_reg <= mprod;
            p1_hprod_reg <= hprod;
            p1_lprod_reg <= lprod;
            p1_index_reg <= p0_reg.index;
            p1_mpos_reg  <= p0_reg.m_pos;
            p2_x_reg     <= x_val;
            p2_side_reg  <= p2_side_next;
        end
    end

    awu_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p2_valid_reg),
        .x         (p2_x_reg),
        .side_in   (p2_side_reg),
        .out_valid (rt_valid),
        .root      (rt_root),
        .side_out  (rt_side)
    );

    // P3: numerator lr*mc in two partial products
    // P4: join, classify zero / saturated cases, set up the divide
    assign num = {p3_nhi_reg, 24'h000000} + 71'(p3_nlo_reg);
    assign p4_side_next.index = p3_side_reg.index;
    assign p4_side_next.m_pos = p3_side_reg.m_pos;
    assign p4_side_next.nz    = (num != '0);
    assign p4_side_next.sat   = (p3_root_reg == 32'd0) |
                                (num[70:32] >= 39'(p3_root_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_nlo_reg  <= 48'(cfg.learning_rate) * 48'(rt_side.mc[23:0]);
            p3_nhi_reg  <= 47'(cfg.learning_rate) * 47'(rt_side.mc[46:24]);
            p3_root_reg <= rt_root;
            p3_side_reg <= rt_side;
            p4_rem_reg  <= num[63:32];
            p4_nlow_reg <= num[31:0];
            p4_dvs_reg  <= p3_root_reg;
            p4_side_reg <= p4_side_next;
        end
    end

    awu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p4_valid_reg),
        .rem0      (p4_rem_reg),
        .nlow      (p4_nlow_reg),
        .dvs       (p4_dvs_reg),
        .side_in   (p4_side_reg),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .side_out  (dv_side)
    );

    // Saturate and sign the step
    assign limit = dv_side.m_pos ? 32'h8000_0000 : 32'h7FFF_FFFF;
    always_comb
    begin
        if (!dv_side.nz)
        begin
            mag  = 32'd0;
            clip = 1'b0;
        end
        else if (dv_side.sat || dv_quo > limit)
        begin
            mag  = limit;
            clip = 1'b1;
        end
        else
        begin
            mag  = dv_quo;
            clip = 1'b0;
        end
    end
    assign out_next.out_index   = dv_side.index;
    assign out_next.weight_step = dv_side.m_pos ? $signed(32'(32'd0 - mag)) : $signed(mag);
    assign out_next.clipped     = clip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p0_valid_reg  <= q_valid;
            p1_valid_reg  <= p0_valid_reg;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= rt_valid;
            p4_valid_reg  <= p3_valid_reg;
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### design/adam_weight_update_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// grad      in         grad_valid/grad_stall grad_data  (index, gradient, fresh)
// step      out        step_valid/step_stall step_data  (index, step, clipped)
// cfg       in         cfg_we                cfg_index, cfg_data
//
// One gradient per cycle while grad_stall is low; a result passes through the 3-stage
// moment update, queue slot, 3 scaling stages, 16-stage root, 2 numerator stages,
// 16-stage divide and output register. An item that reads a weight still being
// written back by one of the three update stages waits for that write.
// Moment memories have no reset; fresh requests start an entry from zero.
// A held result stalls only the back pipeline; the 8-entry queue lets requests
// keep coming until it fills.

module adam_weight_update_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              grad_valid,
    output logic                              grad_stall,
    input  awu_pkg::in_item_t                 grad_data,
    output logic                              step_valid,
    input  logic                              step_stall,
    output awu_pkg::out_item_t                step_data,
    input  logic                              cfg_we,
    input  logic [awu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [awu_pkg::CFG_DATA_W-1:0]    cfg_data
);

    awu_pkg::cfg_t                     cfg_reg;
    logic                              push;
    awu_pkg::moment_t                  push_data;
    logic                              pop;
    logic                              q_not_empty;
    awu_pkg::moment_t                  head_data;
    logic [awu_pkg::Q_CNT_W-1:0]       q_count;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= awu_pkg::CFG_RESET;
        else if (cfg_we)
        begin
            case (cfg_index)
                awu_pkg::CFG_BETA_ONE:       cfg_reg.beta_one       <= cfg_data[23:0];
                awu_pkg::CFG_BETA_TWO:       cfg_reg.beta_two       <= cfg_data[23:0];
                awu_pkg::CFG_LEARNING_RATE:  cfg_reg.learning_rate  <= cfg_data[23:0];
                awu_pkg::CFG_EPSILON_TERM:   cfg_reg.epsilon_term   <= cfg_data[15:0];
                awu_pkg::CFG_BIAS_SCALE_ONE: cfg_reg.bias_scale_one <= cfg_data;
                awu_pkg::CFG_BIAS_SCALE_TWO: cfg_reg.bias_scale_two <= cfg_data;
                default: ;
            endcase
        end
    end

    awu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (grad_valid),
        .in_stall  (grad_stall),
        .in_data   (grad_data),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    awu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_data (head_data),
        .count     (q_count)
    );

    awu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_not_empty),
        .q_data    (head_data),
        .q_pop     (pop),
        .out_valid (step_valid),
        .out_stall (step_stall),
        .out_data  (step_data)
    );

endmodule

### sim/tb_adam_weight_update_unit.sv
`timescale 1ns / 1ps

module tb_adam_weight_update_unit;
    import awu_pkg::*;

    // Predicts each weight step from its own copy of the moments and registers
    class adam_step_predictor;
        cfg_t             regs;
        logic [31:0]      m_mem [NUM_WEIGHTS];
        logic [47:0]      v_mem [NUM_WEIGHTS];
        out_item_t        pending_steps [$];
        int               errors;

        function void clear();
            regs   = CFG_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_BETA_ONE:       regs.beta_one       = val[23:0];
                CFG_BETA_TWO:       regs.beta_two       = val[23:0];
                CFG_LEARNING_RATE:  regs.learning_rate  = val[23:0];
                CFG_EPSILON_TERM:   regs.epsilon_term   = val[15:0];
                CFG_BIAS_SCALE_ONE: regs.bias_scale_one = val;
                CFG_BIAS_SCALE_TWO: regs.bias_scale_two = val;
                default: ;
            endcase
        endfunction

        // integer square root, bit by bit
        function automatic logic [63:0] int_root(logic [63:0] x);
            logic [63:0] rest;
            logic [63:0] res;
            logic [63:0] probe;
            rest  = x;
            res   = 0;
            probe = 64'h1 << 62;
            while (probe > rest)
                probe = probe >> 2;
            while (probe != 0)
            begin
                if (rest >= res + probe)
                begin
                    rest = rest - (res + probe);
                    res  = (res >> 1) + probe;
                end
                else
                    res = res >> 1;
                probe = probe >> 2;
            end
            return res;
        endfunction

        // Accepted gradient request: update moments, queue the expected step
        function void take_gradient(in_item_t it);
            int unsigned  slot;
            longint       g, m_old, m_new, acc;
            logic [63:0]  v_old, v_new, gmag, q, hh, ll, mmag, mc, x_root, r;
            logic [127:0] rc_hi, rc_lo, xsum, num, mag, limit;
            longint       b1, c1;
            logic [63:0]  b2, c2;
            out_item_t    res;
            slot = it.weight_index % NUM_WEIGHTS;
            g    = longint'($signed(it.grad_value));
            if (it.fresh)
            begin
                m_old = 0;
                v_old = 0;
            end
            else
            begin
                m_old = longint'($signed(m_mem[slot]));
                v_old = {16'b0, v_mem[slot]};
            end
            b1    = longint'(regs.beta_one);
            c1    = (longint'(1) << 24) - b1;
            acc   = b1 * m_old + c1 * g + (longint'(1) << 23);
            m_new = acc >>> 24;
            if (m_new > 64'sd2147483647) m_new = 64'sd2147483647;
            if (m_new < -64'sd2147483648) m_new = -64'sd2147483648;

            gmag  = (g < 0) ? -g : g;
            q     = (gmag * gmag + (64'h1 << 15)) >> 16;
            b2    = {40'b0, regs.beta_two};
            c2    = (64'h1 << 24) - b2;
            hh    = b2 * (v_old >> 24) + c2 * (q >> 24);
            ll    = b2 * (v_old & 64'hFFFFFF) + c2 * (q & 64'hFFFFFF);
            v_new = hh + ((ll + (64'h1 << 23)) >> 24);
            if (v_new > {16'b0, MAX_V}) v_new = {16'b0, MAX_V};

            m_mem[slot] = m_new[31:0];
            v_mem[slot] = v_new[47:0];

            mmag  = (m_new < 0) ? -m_new : m_new;
            mc    = (mmag * {32'b0, regs.bias_scale_one} + (64'h1 << 15)) >> 16;
            rc_hi = 128'(v_new >> 16) * 128'(regs.bias_scale_two);
            rc_lo = (128'(v_new & 64'hFFFF) * 128'(regs.bias_scale_two) + (128'h1 << 15)) >> 16;
            if (rc_hi > 128'(MAX_V))
                x_root = {16'b0, MAX_V};
            else
            begin
                xsum = rc_hi + rc_lo + 128'(regs.epsilon_term);
                if (xsum > 128'(MAX_V)) xsum = 128'(MAX_V);
                x_root = xsum[63:0];
            end
            r = int_root(x_root << 16);

            num   = 128'(regs.learning_rate) * 128'(mc);
            limit = (m_new > 0) ? (128'h1 << 31) : (128'h1 << 31) - 1;
            res.clipped = 1'b0;
            if (num == 0)
                mag = 0;
            else if (r == 0)
            begin
                mag = limit;
                res.clipped = 1'b1;
            end
            else
            begin
                mag = num / 128'(r);
                if (mag > limit)
                begin
                    mag = limit;
                    res.clipped = 1'b1;
                end
            end
            res.out_index   = it.weight_index;
            res.weight_step = (m_new > 0) ? -mag[31:0] : mag[31:0];
            pending_steps.insert(pending_steps.size(), res);
        endfunction

        // Accepted step: compare with the oldest expectation
        function void match_step(out_item_t got);
            out_item_t exp_s;
            if (pending_steps.size() == 0)
            begin
                $display("%0t unexpected step: got index %0d step %h clipped %0b",
                         $time, got.out_index, got.weight_step, got.clipped);
                errors++;
                return;
            end
            exp_s = pending_steps.pop_front();
            if (got.out_index !== exp_s.out_index)
            begin
                $display("%0t out_index mismatch: expected %0d actual %0d",
                         $time, exp_s.out_index, got.out_index);
                errors++;
            end
            if (got.weight_step !== exp_s.weight_step)
            begin
                $display("%0t weight_step mismatch (index %0d): expected %h actual %h",
                         $time, exp_s.out_index, exp_s.weight_step, got.weight_step);
                errors++;
            end
            if (got.clipped !== exp_s.clipped)
            begin
                $display("%0t clipped mismatch (index %0d): expected %0b actual %0b",
                         $time, exp_s.out_index, exp_s.clipped, got.clipped);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 grad_valid;
    logic                 grad_stall;
    in_item_t             grad_data;
    logic                 step_valid;
    logic                 step_stall;
    out_item_t            step_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    adam_step_predictor   predictor;
    bit                   written [NUM_WEIGHTS];
    bit                   tx_burst;
    bit                   rx_burst;
    bit                   long_hold;
    bit                   hold_done;
    int                   quiet_cycles = 0;

    adam_weight_update_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .grad_valid (grad_valid),
        .grad_stall (grad_stall),
        .grad_data  (grad_data),
        .step_valid (step_valid),
        .step_stall (step_stall),
        .step_data  (step_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Monitors on both channels, plus the stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (grad_valid && !grad_stall)
                predictor.take_gradient(grad_data);
            if (step_valid && !step_stall)
                predictor.match_step(step_data);
            if ((grad_valid && !grad_stall) || (step_valid && !step_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 5000)
            begin
                $display("adam_weight_update_unit regression: fail");
                $finish;
            end
        end
    end

    // Result side: random stall before each step, one long hold on request
    initial
    begin
        int n;
        step_stall = 1'b0;
        rx_burst   = 1'b0;
        hold_done  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold && !hold_done)
            begin
                @(negedge clk);
                step_stall = 1'b1;
                repeat (400) @(negedge clk);
                hold_done = 1'b1;
            end
            n = rx_burst ? 0 : $urandom_range(0, 17);
            if (n > 0)
            begin
                @(negedge clk);
                step_stall = 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            step_stall = 1'b0;
            do @(posedge clk); while (!step_valid);
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        end
    end

    task automatic send_grad(logic [9:0] idx, logic [31:0] grad, bit fresh);
        in_item_t it;
        int       gap;
        // an entry never written must start fresh
        if (!written[idx % NUM_WEIGHTS]) fresh = 1'b1;
        written[idx % NUM_WEIGHTS] = 1'b1;
        it.weight_index = idx;
        it.grad_value   = grad;
        it.fresh        = fresh;
        // keep offering with no gaps in a burst and while the receiver holds off
        gap = (tx_burst || (long_hold && !hold_done)) ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            @(negedge clk);
            grad_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        grad_data  = it;
        grad_valid = 1'b1;
        do @(posedge clk); while (grad_stall);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        grad_valid = 1'b0;
        cfg_we     = 1'b1;
        cfg_index  = idx;
        cfg_data   = val;
        predictor.write_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_all(logic [31:0] b1, logic [31:0] b2, logic [31:0] lr,
                           logic [31:0] eps, logic [31:0] s1, logic [31:0] s2);
        write_cfg(CFG_BETA_ONE, b1);
        write_cfg(CFG_BETA_TWO, b2);
        write_cfg(CFG_LEARNING_RATE, lr);
        write_cfg(CFG_EPSILON_TERM, eps);
        write_cfg(CFG_BIAS_SCALE_ONE, s1);
        write_cfg(CFG_BIAS_SCALE_TWO, s2);
    endtask

    // Wait for every queued step, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        grad_valid = 1'b0;
        while (predictor.pending_steps.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_grad();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'($signed(16'($urandom)));
            3:       return 32'($signed(24'($urandom)));
            default: return $urandom;
        endcase
    endfunction

    task automatic random_items(int count);
        logic [9:0] idx;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
            idx = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 15))
                                              : 10'($urandom_range(0, 1023));
            send_grad(idx, pick_grad(), $urandom_range(0, 9) == 0);
        end
    endtask

    initial
    begin
        predictor = new();
        predictor.clear();
        rst_n        = 1'b0;
        grad_valid   = 1'b0;
        grad_data    = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        tx_burst     = 1'b0;
        long_hold    = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Phase: reset values, directed extremes and repeated updates
        set_all(15099494, 16760439, 16777, 429, 655360, 65536000);
        send_grad(10'd0,    32'h0000_0000, 1'b1);
        send_grad(10'd1023, 32'h7FFF_FFFF, 1'b1);
        send_grad(10'd1,    32'h8000_0000, 1'b1);
        send_grad(10'd2,    32'hFFFF_FFFF, 1'b1);
        send_grad(10'd3,    32'h0000_0001, 1'b1);
        send_grad(10'd0,    32'h0100_0000, 1'b0);
        send_grad(10'd0,    32'hFF00_0000, 1'b0);
        send_grad(10'd1023, 32'h7FFF_FFFF, 1'b0);
        send_grad(10'd1023, 32'h7FFF_FFFF, 1'b0);
        send_grad(10'd1,    32'h8000_0000, 1'b0);
        send_grad(10'd1,    32'h0000_0000, 1'b0);
        send_grad(10'd682,  32'h5555_5555, 1'b1);
        send_grad(10'd341,  32'hAAAA_AAAA, 1'b1);
        send_grad(10'd682,  32'hAAAA_AAAA, 1'b0);
        send_grad(10'd341,  32'h5555_5555, 1'b0);
        random_items(210);
        drain();

        // Phase: every register at its maximum; receiver holds off long
        set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF);
        long_hold = 1'b1;
        random_items(220);
        drain();

        // Phase: zero decays and zero root (no second-moment scale, no epsilon)
        set_all(0, 0, 32'hFF_FFFF, 0, 32'h1_0000, 0);
        send_grad(10'd5, 32'h0000_0000, 1'b1);
        send_grad(10'd5, 32'h0000_0001, 1'b1);
        send_grad(10'd6, 32'hFFFF_FFFF, 1'b1);
        random_items(200);
        drain();

        // Phase: zero learning rate, zero first bias scale
        set_all($urandom, $urandom, 0, $urandom, 0, $urandom);
        random_items(150);
        drain();

        // Phase: bias correction as software would set it between passes
        set_all(15099494, 16760439, 16777, 429, 32'($urandom_range(65536, 655360)),
                32'($urandom_range(65536, 65536000)));
        random_items(250);
        drain();

        // Phases: fully random registers
        for (int p = 0; p < 2; p++)
        begin
            set_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            random_items(150);
            drain();
        end

        if (predictor.errors == 0 && predictor.pending_steps.size() == 0)
            $display("adam_weight_update_unit regression: pass");
        else
            $display("adam_weight_update_unit regression: fail");
        $finish;
    end

endmodule

### sim.f
design/awu_pkg.sv
design/awu_front.sv
design/awu_queue.sv
design/awu_sqrt.sv
design/awu_div.sv
design/awu_back.sv
design/adam_weight_update_unit.sv
sim/tb_adam_weight_update_unit.sv
